@@ rtl/core/swr_pkg.sv @@
// swr_pkg: shared types and codes of the stop-and-wait retry channels
// no dependencies; used by stop_and_wait_retry_channels

package swr_pkg;

    // field widths
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned SEQ_W    = 24;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned TOUT_W   = 16;
    localparam int unsigned RETRY_W  = 8;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned PEER_W   = 2;
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned MASK_W   = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // request modes
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENQUEUE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RECEIVED = 2'd2;

    // result actions
    localparam logic [ACTION_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SEND    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RESEND  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_GAVE_UP = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DROPPED = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_TIMEOUT = 2'd2;

    // configuration reset values
    localparam logic [TOUT_W-1:0]  ACK_TIMEOUT_RST     = 16'd100;
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST     = 8'd3;
    localparam logic [TOUT_W-1:0]  OFFLINE_TIMEOUT_RST = 16'd3000;

    // one queue entry, tag in the upper bits
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [SEQ_W-1:0] seq;
    } swr_entry_t;

endpackage

@@ rtl/core/stop_and_wait_retry_channels.sv @@
// stop_and_wait_retry_channels: per-peer packet queues with stop-and-wait resend
// depends on swr_pkg (types, codes, widths)
//
//  channel  | signals                                                  | handshake
//  ---------+----------------------------------------------------------+-------------
//  request  | s_mode s_peer_id s_now_ms s_seq_num s_packet_tag s_is_ack | s_valid/s_ready
//  result   | m_action m_peer_id_res m_packet_tag_res m_seq_out         | m_valid/m_ready
//           | m_online_mask m_last                                      |
//  config   | cfg_index cfg_wdata                                       | cfg_wen
//
// a tick visits each channel in turn (ST_TICK_A, then ST_TICK_B), then hands out
// PEER_COUNT results; each channel visit uses the shared 32-bit subtract/compare
// unit twice (ack timeout, then offline timeout) behind one registered queue memory
// read. enqueue, received and ignored requests pass through ST_ONE to a single result.
// s_ready is high only between requests; a stalled m_ready holds the result.
// reset (aresetn low, synchronous) clears all control state; queue contents
// are not cleared and need no clearing pass.

module stop_and_wait_retry_channels #(
    parameter int unsigned QUEUE_DEPTH = 32,
    parameter int unsigned PEER_COUNT  = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [swr_pkg::MODE_W-1:0]         s_mode,
    input  logic [swr_pkg::PEER_W-1:0]         s_peer_id,
    input  logic [swr_pkg::TIME_W-1:0]         s_now_ms,
    input  logic [swr_pkg::SEQ_W-1:0]          s_seq_num,
    input  logic [swr_pkg::TAG_W-1:0]          s_packet_tag,
    input  logic                               s_is_ack,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [swr_pkg::ACTION_W-1:0]       m_action,
    output logic [swr_pkg::PEER_W-1:0]         m_peer_id_res,
    output logic [swr_pkg::TAG_W-1:0]          m_packet_tag_res,
    output logic [swr_pkg::SEQ_W-1:0]          m_seq_out,
    output logic [swr_pkg::MASK_W-1:0]         m_online_mask,
    output logic                               m_last,
    // configuration write port
    input  logic                               cfg_wen,
    input  logic [swr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int unsigned CH_W   = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
    localparam int unsigned PW     = (CH_W > swr_pkg::PEER_W) ? CH_W : swr_pkg::PEER_W;
    localparam int unsigned HEAD_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W  = CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ONE,
        ST_TICK_A,
        ST_TICK_B,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [swr_pkg::TOUT_W-1:0]  ack_timeout_reg;
    logic [swr_pkg::RETRY_W-1:0] max_retries_reg;
    logic [swr_pkg::TOUT_W-1:0]  offline_timeout_reg;

    // latched request
    logic [swr_pkg::MODE_W-1:0] mode_reg;
    logic [swr_pkg::PEER_W-1:0] pid_reg;
    logic [swr_pkg::TIME_W-1:0] now_reg;
    logic [swr_pkg::SEQ_W-1:0]  seq_reg;
    logic [swr_pkg::TAG_W-1:0]  tag_reg;
    logic                       ack_reg;
    logic                       pid_ok_reg;

    // per-channel state
    logic [HEAD_W-1:0]            head_reg     [PEER_COUNT];
    logic [CNT_W-1:0]             count_reg    [PEER_COUNT];
    logic [PEER_COUNT-1:0]        waiting_reg;
    logic [swr_pkg::RETRY_W-1:0]  retry_reg    [PEER_COUNT];
    logic [swr_pkg::TIME_W-1:0]   send_time_reg[PEER_COUNT];
    swr_pkg::swr_entry_t          inflight_reg [PEER_COUNT];
    logic [PEER_COUNT-1:0]        online_reg;
    logic [swr_pkg::TIME_W-1:0]   seen_time_reg[PEER_COUNT];

    // sequencer
    logic [CH_W-1:0] ch_reg;
    logic [CH_W-1:0] out_idx_reg;
    logic            single_reg;
    logic            ack_late_reg;

    // result buffer, one slot per channel
    logic [swr_pkg::ACTION_W-1:0] act_buf_reg [PEER_COUNT];
    logic [swr_pkg::PEER_W-1:0]   peer_buf_reg[PEER_COUNT];
    swr_pkg::swr_entry_t          ent_buf_reg [PEER_COUNT];

    // queue memory
    swr_pkg::swr_entry_t mem [PEER_COUNT][QUEUE_DEPTH];
    swr_pkg::swr_entry_t rd_data_reg;

    // request decode
    logic [PW-1:0]   s_pidx;
    logic            s_pid_ok;
    assign s_pidx   = PW'(s_peer_id) - PW'(1);
    assign s_pid_ok = (s_peer_id != '0) && (32'(s_peer_id) <= PEER_COUNT);

    // shared subtract/compare unit: elapsed time against a threshold
    logic [swr_pkg::TIME_W-1:0] unit_op;
    logic [swr_pkg::TOUT_W-1:0] unit_thr;
    logic [swr_pkg::TIME_W-1:0] unit_elapsed;
    logic                       unit_gt;

    always_comb begin
        if (state_reg == ST_TICK_A) begin
            unit_op  = send_time_reg[ch_reg];
            unit_thr = ack_timeout_reg;
        end else begin
            unit_op  = seen_time_reg[ch_reg];
            unit_thr = offline_timeout_reg;
        end
        unit_elapsed = now_reg - unit_op;
        unit_gt      = unit_elapsed > swr_pkg::TIME_W'(unit_thr);
    end

    // enqueue slot and fullness of the addressed channel
    logic [SUM_W-1:0]  tail_sum;
    logic [HEAD_W-1:0] tail_slot;
    logic              queue_full;
    logic              is_enqueue;
    logic              is_received;
    logic              mem_we;
    logic [HEAD_W-1:0] head_inc;

    always_comb begin
        tail_sum = SUM_W'(head_reg[ch_reg]) + SUM_W'(count_reg[ch_reg]);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            tail_slot = HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
        end else begin
            tail_slot = HEAD_W'(tail_sum);
        end
        queue_full  = count_reg[ch_reg] == CNT_W'(QUEUE_DEPTH);
        is_enqueue  = pid_ok_reg && (mode_reg == swr_pkg::MODE_ENQUEUE);
        is_received = pid_ok_reg && (mode_reg == swr_pkg::MODE_RECEIVED);
        mem_we      = (state_reg == ST_ONE) && is_enqueue && !queue_full;
        if (head_reg[ch_reg] == HEAD_W'(QUEUE_DEPTH - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = head_reg[ch_reg] + HEAD_W'(1);
        end
    end

    // queue memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ch_reg][tail_slot] <= {tag_reg, seq_reg};
        end
        if (state_reg == ST_TICK_A) begin
            rd_data_reg <= mem[ch_reg][head_reg[ch_reg]];
        end
    end

    // sequencer, channel state and result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            ack_timeout_reg     <= swr_pkg::ACK_TIMEOUT_RST;
            max_retries_reg     <= swr_pkg::MAX_RETRIES_RST;
            offline_timeout_reg <= swr_pkg::OFFLINE_TIMEOUT_RST;
            ch_reg              <= '0;
            out_idx_reg         <= '0;
            single_reg          <= 1'b0;
            waiting_reg         <= '0;
            online_reg          <= '0;
            for (int i = 0; i < PEER_COUNT; i++) begin
                head_reg[i]      <= '0;
                count_reg[i]     <= '0;
                retry_reg[i]     <= '0;
                send_time_reg[i] <= '0;
                inflight_reg[i]  <= '0;
                seen_time_reg[i] <= '0;
            end
        end else begin
            // configuration writes
            if (cfg_wen) begin
                case (cfg_index)
                    swr_pkg::CFG_ACK_TIMEOUT:     ack_timeout_reg     <= cfg_wdata;
                    swr_pkg::CFG_MAX_RETRIES:     max_retries_reg     <= cfg_wdata[swr_pkg::RETRY_W-1:0];
                    swr_pkg::CFG_OFFLINE_TIMEOUT: offline_timeout_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            case (state_reg)
                // take a request
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg   <= s_mode;
                        pid_reg    <= s_peer_id;
                        now_reg    <= s_now_ms;
                        seq_reg    <= s_seq_num;
                        tag_reg    <= s_packet_tag;
                        ack_reg    <= s_is_ack;
                        pid_ok_reg <= s_pid_ok;
                        if (s_mode == swr_pkg::MODE_TICK) begin
                            ch_reg    <= '0;
                            state_reg <= ST_TICK_A;
                        end else begin
                            ch_reg    <= s_pid_ok ? s_pidx[CH_W-1:0] : '0;
                            state_reg <= ST_ONE;
                        end
                    end
                end

                // enqueue, received or ignored request
                ST_ONE: begin
                    act_buf_reg[0]  <= swr_pkg::ACT_NONE;
                    peer_buf_reg[0] <= '0;
                    ent_buf_reg[0]  <= '0;
                    if (is_enqueue) begin
                        peer_buf_reg[0] <= pid_reg;
                        if (queue_full) begin
                            act_buf_reg[0] <= swr_pkg::ACT_DROPPED;
                            ent_buf_reg[0] <= {tag_reg, seq_reg};
                        end else begin
                            count_reg[ch_reg] <= count_reg[ch_reg] + CNT_W'(1);
                        end
                    end else if (is_received) begin
                        peer_buf_reg[0]       <= pid_reg;
                        online_reg[ch_reg]    <= 1'b1;
                        seen_time_reg[ch_reg] <= now_reg;
                        if (ack_reg && waiting_reg[ch_reg] &&
                            (inflight_reg[ch_reg].seq == seq_reg)) begin
                            waiting_reg[ch_reg] <= 1'b0;
                            retry_reg[ch_reg]   <= '0;
                        end
                    end
                    out_idx_reg <= '0;
                    single_reg  <= 1'b1;
                    state_reg   <= ST_EMIT;
                end

                // ack timeout compare, queue head read
                ST_TICK_A: begin
                    ack_late_reg <= unit_gt;
                    state_reg    <= ST_TICK_B;
                end

                // channel action and offline compare
                ST_TICK_B: begin
                    act_buf_reg[ch_reg]  <= swr_pkg::ACT_NONE;
                    ent_buf_reg[ch_reg]  <= '0;
                    peer_buf_reg[ch_reg] <= swr_pkg::PEER_W'(PW'(ch_reg) + PW'(1));
                    if (waiting_reg[ch_reg]) begin
                        if (ack_late_reg) begin
                            ent_buf_reg[ch_reg] <= inflight_reg[ch_reg];
                            if (retry_reg[ch_reg] < max_retries_reg) begin
                                act_buf_reg[ch_reg]   <= swr_pkg::ACT_RESEND;
                                retry_reg[ch_reg]     <= retry_reg[ch_reg] + swr_pkg::RETRY_W'(1);
                                send_time_reg[ch_reg] <= now_reg;
                            end else begin
                                act_buf_reg[ch_reg] <= swr_pkg::ACT_GAVE_UP;
                                waiting_reg[ch_reg] <= 1'b0;
                                online_reg[ch_reg]  <= 1'b0;
                            end
                        end
                    end else if (count_reg[ch_reg] != '0) begin
                        head_reg[ch_reg]      <= head_inc;
                        count_reg[ch_reg]     <= count_reg[ch_reg] - CNT_W'(1);
                        inflight_reg[ch_reg]  <= rd_data_reg;
                        retry_reg[ch_reg]     <= '0;
                        send_time_reg[ch_reg] <= now_reg;
                        waiting_reg[ch_reg]   <= 1'b1;
                        act_buf_reg[ch_reg]   <= swr_pkg::ACT_SEND;
                        ent_buf_reg[ch_reg]   <= rd_data_reg;
                    end
                    // silent peer goes offline
                    if ((seen_time_reg[ch_reg] != '0) && unit_gt) begin
                        online_reg[ch_reg] <= 1'b0;
                    end
                    if (ch_reg == CH_W'(PEER_COUNT - 1)) begin
                        out_idx_reg <= '0;
                        single_reg  <= 1'b0;
                        state_reg   <= ST_EMIT;
                    end else begin
                        ch_reg    <= ch_reg + CH_W'(1);
                        state_reg <= ST_TICK_A;
                    end
                end

                // hand out buffered results
                ST_EMIT: begin
                    if (m_ready) begin
                        if (m_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            out_idx_reg <= out_idx_reg + CH_W'(1);
                        end
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result channel
    logic [PEER_COUNT+swr_pkg::MASK_W-1:0] online_pad;
    assign online_pad = {{swr_pkg::MASK_W{1'b0}}, online_reg};

    assign s_ready          = state_reg == ST_IDLE;
    assign m_valid          = state_reg == ST_EMIT;
    assign m_action         = act_buf_reg[out_idx_reg];
    assign m_peer_id_res    = peer_buf_reg[out_idx_reg];
    assign m_packet_tag_res = ent_buf_reg[out_idx_reg].tag;
    assign m_seq_out        = ent_buf_reg[out_idx_reg].seq;
    assign m_online_mask    = online_pad[swr_pkg::MASK_W-1:0];
    assign m_last           = single_reg || (out_idx_reg == CH_W'(PEER_COUNT - 1));

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while results pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready did not drop after a request");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("not idle after the last result");

    a_single_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && single_reg) |-> (out_idx_reg == '0))
        else $error("single result read past slot zero");

    for (genvar g = 0; g < PEER_COUNT; g++) begin : g_chk
        a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
            count_reg[g] <= CNT_W'(QUEUE_DEPTH))
            else $error("queue count beyond depth");
    end

endmodule
